/* hdl/btpc_pkg.sv */
package btpc_pkg;

   localparam int DATA_W = 32;
   localparam int STEP_W = 5;

   localparam logic [DATA_W-1:0] T_OFFSET   = 32'd64000;
   localparam logic [DATA_W-1:0] P_FULL     = 32'd1048576;
   localparam logic [DATA_W-1:0] P_SCALE    = 32'd3125;
   localparam logic [DATA_W-1:0] SIGN_BIT   = 32'h80000000;
   localparam logic [DATA_W-1:0] P1_BIAS    = 32'd32768;
   localparam logic [DATA_W-1:0] T_ROUND    = 32'd128;
   localparam logic [DATA_W-1:0] DIV_TEN    = 32'd10;
   // magnitudes at or above this already saturate after the divide by ten
   localparam logic [DATA_W-1:0] DIV_LIMIT  = 32'd327680;
   // 13107 / 2^17 sits just under 1/10; the estimate is at most one low
   localparam logic [DATA_W-1:0] DIV_RECIP  = 32'd13107;

   localparam logic [1:0] REG_TEMP    = 2'd0;
   localparam logic [1:0] REG_PRESS_A = 2'd1;
   localparam logic [1:0] REG_PRESS_B = 2'd2;
   localparam logic [1:0] REG_PRESS_C = 2'd3;

   localparam logic KIND_TEMP  = 1'b0;
   localparam logic KIND_PRESS = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_CALC = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   typedef struct packed {
      logic              start;
      logic [DATA_W-1:0] dividend;
      logic [DATA_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [DATA_W-1:0] quotient;
   } div_rsp_type;

endpackage

/* hdl/btpc_div.sv */
module btpc_div (
   input  logic                 clock,
   input  logic                 reset,
   input  btpc_pkg::div_req_type req,
   output btpc_pkg::div_rsp_type rsp
);
   import btpc_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [4:0]        count_ff, count_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] quo_ff, quo_in;
   logic [DATA_W-1:0] den_ff, den_in;
   logic [DATA_W:0]   trial;

   assign trial = {rem_ff, quo_ff[DATA_W-1]} - {1'b0, den_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      den_in   = den_ff;
      if (req.start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = '0;
         quo_in   = req.dividend;
         den_in   = req.divisor;
      end else if (busy_ff) begin
         // restoring step, one quotient bit per cycle
         if (!trial[DATA_W]) begin
            rem_in = trial[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[DATA_W-2:0], quo_ff[DATA_W-1]};
            quo_in = {quo_ff[DATA_W-2:0], 1'b0};
         end
         count_in = count_ff + 5'd1;
         if (count_ff == 5'(DATA_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

/* hdl/baro_temp_pressure_compensation.sv */
// Barometric compensation, 32-bit integer scheme. A temperature transfer
// (tuser 0) updates the kept fine temperature and returns 0.1 degC; a pressure
// transfer (tuser 1) returns 10 Pa using the last fine temperature. One shared
// 32x32 multiplier (low 32 bits kept) is stepped by a sequencer. The pressure
// divide runs through a one-bit-per-cycle divider, which a zero divisor skips;
// the final divides by ten use a reciprocal multiply on the clamped magnitude
// and one correction step. One item is in flight at a time; the input is
// ready again the cycle after the result transfer. Coefficients must be
// written while idle.
module baro_temp_pressure_compensation (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [19:0] raw_sample
   input  logic        req_tuser,   // [0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] reading
   output logic [1:0]  rsp_tuser,   // [0] kind_out, [1] divisor_zero
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [47:0] csr_wdata
);
   import btpc_pkg::*;

   function automatic logic [DATA_W-1:0] asr(input logic [DATA_W-1:0] x,
                                             input logic [4:0] n);
      return $signed(x) >>> n;
   endfunction

   function automatic logic [DATA_W-1:0] sx16(input logic [15:0] x);
      return {{16{x[15]}}, x};
   endfunction

   function automatic logic [DATA_W-1:0] clamp_lim(input logic [DATA_W-1:0] x);
      return (x > DIV_LIMIT) ? DIV_LIMIT : x;
   endfunction

   // remainder of 10..19 means the reciprocal estimate came out one low
   function automatic logic [DATA_W-1:0] fix_tenth(input logic [DATA_W-1:0] x,
                                                   input logic [DATA_W-1:0] q);
      logic [DATA_W-1:0] r;
      r = x - ({q[DATA_W-4:0], 3'b0} + {q[DATA_W-2:0], 1'b0});
      return (r >= DIV_TEN) ? q + 32'd1 : q;
   endfunction

   logic [47:0] temp_ff, pa_ff, pb_ff, pc_ff;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              kind_ff, kind_in;
   logic [19:0]       raw_ff, raw_in;
   logic              flag_ff, flag_in;
   logic [DATA_W-1:0] fine_ff, fine_in;
   logic [DATA_W-1:0] ra_ff, ra_in, rb_ff, rb_in, rc_ff, rc_in, rd_ff, rd_in;
   logic [15:0]       rd_out_ff, rd_out_in;
   logic              dz_ff, dz_in;

   logic [DATA_W-1:0] mul_a, mul_b, prod;
   div_req_type       dreq;
   div_rsp_type       drsp;
   logic [DATA_W-1:0] neg_q;

   logic [DATA_W-1:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
   assign t1 = {16'b0, temp_ff[15:0]};
   assign t2 = sx16(temp_ff[31:16]);
   assign t3 = sx16(temp_ff[47:32]);
   assign p1 = {16'b0, pa_ff[15:0]};
   assign p2 = sx16(pa_ff[31:16]);
   assign p3 = sx16(pa_ff[47:32]);
   assign p4 = sx16(pb_ff[15:0]);
   assign p5 = sx16(pb_ff[31:16]);
   assign p6 = sx16(pb_ff[47:32]);
   assign p7 = sx16(pc_ff[15:0]);
   assign p8 = sx16(pc_ff[31:16]);
   assign p9 = sx16(pc_ff[47:32]);

   btpc_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (dreq),
      .rsp   (drsp)
   );

   // shared multiplier operands per step
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == ST_CALC) begin
         if (kind_ff == KIND_TEMP) begin
            case (step_ff)
               5'd0: begin
                  mul_a = {15'b0, raw_ff[19:3]} - {15'b0, t1[15:0], 1'b0};
                  mul_b = t2;
               end
               5'd1: begin mul_a = rd_ff;              mul_b = rd_ff;     end
               5'd2: begin mul_a = asr(rb_ff, 5'd12);  mul_b = t3;        end
               5'd4: begin mul_a = fine_ff;            mul_b = 32'd5;     end
               5'd6: begin mul_a = rb_ff;              mul_b = DIV_RECIP; end
               default: ;
            endcase
         end else begin
            case (step_ff)
               5'd1:  begin mul_a = asr(ra_ff, 5'd2);  mul_b = asr(ra_ff, 5'd2); end
               5'd2:  begin mul_a = asr(rb_ff, 5'd11); mul_b = p6;               end
               5'd3:  begin mul_a = ra_ff;             mul_b = p5;               end
               5'd5:  begin mul_a = p3;                mul_b = asr(rb_ff, 5'd13); end
               5'd6:  begin mul_a = p2;                mul_b = ra_ff;            end
               5'd7:  begin mul_a = P1_BIAS + ra_ff;   mul_b = p1;               end
               5'd8:  begin
                  mul_a = (P_FULL - {12'b0, raw_ff}) - asr(rc_ff, 5'd12);
                  mul_b = P_SCALE;
               end
               5'd11: begin mul_a = rd_ff >> 3;        mul_b = rd_ff >> 3;       end
               5'd12: begin mul_a = p9;                mul_b = rb_ff >> 13;      end
               5'd13: begin mul_a = rd_ff >> 2;        mul_b = p8;               end
               5'd16: begin mul_a = rb_ff;             mul_b = DIV_RECIP;        end
               default: ;
            endcase
         end
      end
   end

   assign prod  = 32'(mul_a * mul_b);
   assign neg_q = -rd_ff;

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      kind_in   = kind_ff;
      raw_in    = raw_ff;
      flag_in   = flag_ff;
      fine_in   = fine_ff;
      ra_in     = ra_ff;
      rb_in     = rb_ff;
      rc_in     = rc_ff;
      rd_in     = rd_ff;
      rd_out_in = rd_out_ff;
      dz_in     = dz_ff;
      dreq      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               kind_in  = req_tuser;
               raw_in   = req_tdata[19:0];
               dz_in    = 1'b0;
               step_in  = '0;
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            step_in = step_ff + 5'd1;
            if (kind_ff == KIND_TEMP) begin
               case (step_ff)
                  5'd0: begin
                     ra_in = prod;
                     rd_in = {16'b0, raw_ff[19:4]} - t1;
                  end
                  5'd1: rb_in = prod;
                  5'd2: rb_in = prod;
                  5'd3: fine_in = asr(ra_ff, 5'd11) + asr(rb_ff, 5'd14);
                  5'd4: ra_in = asr(prod + T_ROUND, 5'd8);
                  5'd5: begin
                     flag_in = ra_ff[DATA_W-1];
                     rb_in   = clamp_lim(ra_ff[DATA_W-1] ? -ra_ff : ra_ff);
                  end
                  5'd6: rc_in = prod >> 17;
                  5'd7: rd_in = fix_tenth(rb_ff, rc_ff);
                  default: begin
                     // magnitude is at most 32768 here
                     if (flag_ff)
                        rd_out_in = neg_q[15:0];
                     else if (rd_ff > 32'd32767)
                        rd_out_in = 16'h7fff;
                     else
                        rd_out_in = rd_ff[15:0];
                     state_in = ST_DONE;
                  end
               endcase
            end else begin
               case (step_ff)
                  5'd0: ra_in = asr(fine_ff, 5'd1) - T_OFFSET;
                  5'd1: rb_in = prod;
                  5'd2: rc_in = prod;
                  5'd3: rc_in = rc_ff + {prod[DATA_W-2:0], 1'b0};
                  5'd4: rc_in = asr(rc_ff, 5'd2) + {p4[15:0], 16'b0};
                  5'd5: rb_in = prod;
                  5'd6: ra_in = asr(asr(rb_ff, 5'd3) + asr(prod, 5'd1), 5'd18);
                  5'd7: ra_in = asr(prod, 5'd15);
                  5'd8: begin
                     rd_in = prod;
                     if (ra_ff == '0) begin
                        rd_out_in = '0;
                        dz_in     = 1'b1;
                        state_in  = ST_DONE;
                     end
                  end
                  5'd9: begin
                     flag_in       = rd_ff[DATA_W-1];
                     dreq.start    = 1'b1;
                     dreq.dividend = rd_ff[DATA_W-1] ? rd_ff
                                                     : {rd_ff[DATA_W-2:0], 1'b0};
                     dreq.divisor  = ra_ff;
                     state_in      = ST_DIV;
                  end
                  5'd10: rd_in = flag_ff ? {drsp.quotient[DATA_W-2:0], 1'b0}
                                         : drsp.quotient;
                  5'd11: rb_in = prod;
                  5'd12: ra_in = asr(prod, 5'd12);
                  5'd13: rc_in = asr(prod, 5'd13);
                  5'd14: rd_in = rd_ff + asr(ra_ff + rc_ff + p7, 5'd4);
                  5'd15: rb_in = clamp_lim(rd_ff);
                  5'd16: rc_in = prod >> 17;
                  5'd17: rd_in = fix_tenth(rb_ff, rc_ff);
                  default: begin
                     rd_out_in = (rd_ff > 32'd32767) ? 16'h7fff : rd_ff[15:0];
                     state_in  = ST_DONE;
                  end
               endcase
            end
         end
         ST_DIV: begin
            if (drsp.done)
               state_in = ST_CALC;
         end
         ST_DONE: begin
            if (rsp_tready)
               state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         fine_ff  <= '0;
         temp_ff  <= '0;
         pa_ff    <= '0;
         pb_ff    <= '0;
         pc_ff    <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         fine_ff  <= fine_in;
         if (csr_we) begin
            case (csr_index)
               REG_TEMP:    temp_ff <= csr_wdata;
               REG_PRESS_A: pa_ff   <= csr_wdata;
               REG_PRESS_B: pb_ff   <= csr_wdata;
               REG_PRESS_C: pc_ff   <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      raw_ff    <= raw_in;
      flag_ff   <= flag_in;
      ra_ff     <= ra_in;
      rb_ff     <= rb_in;
      rc_ff     <= rc_in;
      rd_ff     <= rd_in;
      rd_out_ff <= rd_out_in;
      dz_ff     <= dz_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_DONE);
   assign rsp_tdata  = rd_out_ff;
   assign rsp_tuser  = {dz_ff, kind_ff};

endmodule

/* hdl/btpc_checker.sv */
module btpc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   // held result stays put until taken
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // one item in flight: never ready while a result is pending
   a_single: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input ready with result pending");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !rsp_tvalid && !req_tready)
      else $error("result too early after accept");

   a_dz: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tuser[0] && (rsp_tdata == 16'h0000))
      else $error("bad zero-divisor result");

endmodule

bind baro_temp_pressure_compensation btpc_checker u_btpc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

/* tb/tb_baro_temp_pressure_compensation.sv */
module tb_baro_temp_pressure_compensation;
   timeunit 1ns;
   timeprecision 1ps;

   import btpc_pkg::*;

   typedef struct packed {
      logic        kind;
      logic [15:0] reading;
      logic        dz;
   } reading_type;

   typedef struct {
      logic        kind;
      logic [19:0] raw;
      logic        has_exp;
      logic [15:0] exp_reading;
      logic        exp_dz;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [47:0] csr_wdata = '0;

   // model copy of coefficients and kept fine temperature
   logic [47:0] m_temp, m_pa, m_pb, m_pc;
   logic [31:0] m_fine;

   reading_type expected_q[$];
   int          mismatches = 0;
   int          idle_cycles = 0;
   int          rsp_gap = 0;
   bit          hold_long = 0;
   dir_row_type dir_rows[$];

   baro_temp_pressure_compensation uut (.*);

   always #10 clock = ~clock;

   function automatic logic [31:0] sfield(logic [47:0] r, int k);
      return {{16{r[16*k+15]}}, r[16*k +: 16]};
   endfunction

   function automatic logic [31:0] asr(logic [31:0] x, int n);
      return $signed(x) >>> n;
   endfunction

   function automatic logic [15:0] sat16(longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'h8000;
      return v[15:0];
   endfunction

   function automatic reading_type compensate(logic kind, logic [19:0] raw);
      reading_type r;
      logic [31:0] t1, t2, t3, a, d, b, t, rw;
      logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, v1, v2, q, sq, p;
      rw = {12'd0, raw};
      r.kind = kind;
      r.dz = 1'b0;
      if (kind == KIND_TEMP) begin
         t1 = {16'd0, m_temp[15:0]};
         t2 = sfield(m_temp, 1);
         t3 = sfield(m_temp, 2);
         a = ((rw >> 3) - (t1 << 1)) * t2;
         d = (rw >> 4) - t1;
         b = asr(d * d, 12) * t3;
         m_fine = asr(a, 11) + asr(b, 14);
         t = asr(m_fine * 32'd5 + T_ROUND, 8);
         r.reading = sat16(longint'($signed(t) / 10));
      end else begin
         p1 = {16'd0, m_pa[15:0]};
         p2 = sfield(m_pa, 1); p3 = sfield(m_pa, 2);
         p4 = sfield(m_pb, 0); p5 = sfield(m_pb, 1); p6 = sfield(m_pb, 2);
         p7 = sfield(m_pc, 0); p8 = sfield(m_pc, 1); p9 = sfield(m_pc, 2);
         v1 = asr(m_fine, 1) - T_OFFSET;
         q = asr(v1, 2);
         sq = q * q;
         v2 = asr(sq, 11) * p6;
         v2 = v2 + ((v1 * p5) << 1);
         v2 = asr(v2, 2) + (p4 << 16);
         v1 = asr(asr(p3 * asr(sq, 13), 3) + asr(p2 * v1, 1), 18);
         v1 = asr((P1_BIAS + v1) * p1, 15);
         if (v1 == 0) begin
            r.reading = '0;
            r.dz = 1'b1;
         end else begin
            p = ((P_FULL - rw) - asr(v2, 12)) * P_SCALE;
            if (p < SIGN_BIT) p = (p << 1) / v1;
            else p = (p / v1) * 32'd2;
            v1 = asr(p9 * (((p >> 3) * (p >> 3)) >> 13), 12);
            v2 = asr((p >> 2) * p8, 13);
            p = p + asr(v1 + v2 + p7, 4);
            r.reading = sat16(longint'(p / DIV_TEN));
         end
      end
      return r;
   endfunction

   task automatic write_coeffs(logic [1:0] idx, logic [47:0] val);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_TEMP:    m_temp = val;
         REG_PRESS_A: m_pa = val;
         REG_PRESS_B: m_pb = val;
         default:     m_pc = val;
      endcase
      @(posedge clock);
   endtask

   task automatic wait_empty();
      req_tvalid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
   endtask

   task automatic drain_then_settle();
      wait_empty();
      repeat (100) @(posedge clock);
   endtask

   task automatic drive_item(logic kind, logic [19:0] raw, reading_type want);
      int gap;
      gap = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {4'd0, raw};
      expected_q.push_back(want);
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_sample(logic kind, logic [19:0] raw);
      drive_item(kind, raw, compensate(kind, raw));
   endtask

   // typical calibration set, lightly randomized
   function automatic logic [47:0] rnd_reg(int which);
      case (which)
         0: return {16'($urandom_range(0, 100)), 16'($urandom_range(26000, 27000)),
                    16'($urandom_range(27000, 28500))};
         1: return {16'(-$urandom_range(5000, 6500)), 16'(-$urandom_range(10000, 11000)),
                    16'($urandom_range(35000, 38000))};
         2: return {16'(-$urandom_range(0, 10)), 16'($urandom_range(100, 200)),
                    16'($urandom_range(2000, 9000))};
         default: return {16'($urandom_range(5000, 6500)), 16'(-$urandom_range(10000, 15000)),
                          16'($urandom_range(0, 16000))};
      endcase
   endfunction

   // result checker
   always @(posedge clock) begin
      reading_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{kind: rsp_tuser[0], reading: rsp_tdata, dz: rsp_tuser[1]};
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected transfer %p", got);
         end else begin
            want = expected_q.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp kind=%0d reading=%0d dz=%0d got kind=%0d reading=%0d dz=%0d",
                           want.kind, $signed(want.reading), want.dz,
                           got.kind, $signed(got.reading), got.dz);
            end
         end
      end
   end

   // receiver stalls: mostly short, a few long
   always @(posedge clock) begin
      if (reset || hold_long) begin
         rsp_tready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_tready <= 1'b0;
         rsp_gap <= rsp_gap - 1;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_tready <= 1'b0;
         rsp_gap <= ($urandom_range(0, 19) == 0) ? int'($urandom_range(10, 60))
                                                 : int'($urandom_range(0, 2));
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset || hold_long)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // long receiver hold-off while the sender keeps offering
   initial begin
      repeat (3000) @(posedge clock);
      hold_long = 1;
      repeat (800) @(posedge clock);
      hold_long = 0;
   end

   initial begin
      dir_row_type row;
      reading_type exp_r;
      logic [19:0] raw;
      m_temp = '0; m_pa = '0; m_pb = '0; m_pc = '0; m_fine = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // all coefficients zero: temperature reads 0, pressure divisor is zero
      dir_rows.push_back('{KIND_PRESS, 20'd0,     1'b1, 16'd0, 1'b1});
      dir_rows.push_back('{KIND_TEMP,  20'd0,     1'b1, 16'd0, 1'b0});
      dir_rows.push_back('{KIND_TEMP,  20'hFFFFF, 1'b1, 16'd0, 1'b0});
      dir_rows.push_back('{KIND_PRESS, 20'hFFFFF, 1'b1, 16'd0, 1'b1});
      foreach (dir_rows[i]) begin
         row = dir_rows[i];
         exp_r = compensate(row.kind, row.raw);
         if (row.has_exp)
            exp_r = '{kind: row.kind, reading: row.exp_reading, dz: row.exp_dz};
         drive_item(row.kind, row.raw, exp_r);
      end
      drain_then_settle();

      // typical calibration, then extremes
      for (int r = 0; r < 4; r++) write_coeffs(r[1:0], rnd_reg(r));
      send_sample(KIND_PRESS, 20'h65000);
      send_sample(KIND_TEMP, 20'h7E000);
      send_sample(KIND_PRESS, 20'h65000);
      send_sample(KIND_TEMP, 20'hFFFFF);
      send_sample(KIND_PRESS, 20'hFFFFF);
      send_sample(KIND_TEMP, 20'h00000);
      send_sample(KIND_PRESS, 20'h00000);
      send_sample(KIND_TEMP, 20'h55555);
      send_sample(KIND_PRESS, 20'hAAAAA);
      drain_then_settle();
      write_coeffs(REG_TEMP, 48'hFFFF_FFFF_FFFF);
      write_coeffs(REG_PRESS_A, 48'h8000_8000_FFFF);
      write_coeffs(REG_PRESS_B, 48'h7FFF_7FFF_7FFF);
      write_coeffs(REG_PRESS_C, 48'h8000_7FFF_8000);
      send_sample(KIND_TEMP, 20'hFFFFF);
      send_sample(KIND_PRESS, 20'h00000);
      send_sample(KIND_TEMP, 20'h12345);
      send_sample(KIND_PRESS, 20'hFFFFF);
      drain_then_settle();

      // random phases
      for (int ph = 0; ph < 6; ph++) begin
         for (int r = 0; r < 4; r++)
            write_coeffs(r[1:0], (ph == 5) ? 48'($urandom()) << 16 | 48'($urandom())
                                           : rnd_reg(r));
         for (int n = 0; n < 250; n++) begin
            if (ph >= 4 || $urandom_range(0, 9) == 0) raw = 20'($urandom());
            else raw = 20'($urandom_range(300000, 560000));
            send_sample(1'($urandom_range(0, 2) != 0), raw);
            if (n == 125) wait_empty();
         end
         drain_then_settle();
      end

      if (mismatches == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end
endmodule
